FILE: sv/bisection_square_root_top_assert.svh
// Assertion macros for the bisection square root block.
// Each macro expands to one labelled concurrent assertion clocked on clk_i
// and switched off while rst_ni is low.
`ifndef BISECTION_SQUARE_ROOT_TOP_ASSERT_SVH
`define BISECTION_SQUARE_ROOT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared widths, codes and control types of the bisection square root block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

  localparam int DATA_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int ITER_W        = 7;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_ITER_DEF  = 100;
  localparam logic [DATA_W-1:0] TOL_RESET = 32'd66;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONVERGED     = 2'd0,
    ST_EXACT         = 2'd1,
    ST_NOT_CONVERGED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_CMP  = 2'd2
  } state_e;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit_mid;
  } bsr_cmd_t;

  // Datapath flags back to the sequencer
  typedef struct packed {
    logic zero;
    logic one;
    logic hit;
    logic below;
  } bsr_flag_t;

endpackage

`default_nettype wire

FILE: sv/bsr_datapath.sv
// ----------------------------------------------------------------------------
// bsr_datapath
// Interval registers, shared squaring multiplier and tolerance compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsr_datapath #(
  parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         tolerance_we_i,
  input  wire logic [bsr_pkg::DATA_W-1:0]   tolerance_i,
  input  wire logic [bsr_pkg::DATA_W-1:0]   value_i,
  input  wire bsr_pkg::bsr_cmd_t            cmd_i,
  output bsr_pkg::bsr_flag_t                flag_o,
  output logic [bsr_pkg::DATA_W-1:0]        root_o
);

  localparam int DataW = bsr_pkg::DATA_W;
  localparam int SqW   = 2 * DataW;
  localparam int PadW  = SqW - DataW - FRAC_BITS;
  localparam logic [DataW-1:0] One = {{(DataW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [DataW-1:0] tol_q;
  logic [DataW-1:0] val_q;
  logic [DataW-1:0] lo_q, hi_q, mid_q, up_q, dn_q, root_q;
  logic [DataW-1:0] lo_d, hi_d, mid_d, up_d, dn_d, root_d, hi_init;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [DataW:0]   sum_up, sum_dn;
  logic [SqW-1:0]   target, tol_wide, diff;
  logic [SqW:0]     sub_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= bsr_pkg::TOL_RESET;
    end else if (tolerance_we_i) begin
      tol_q <= tolerance_i;
    end
  end

  assign hi_init = (value_i > One) ? value_i : One;

  // Both candidate midpoints for the next step are ready with the square
  assign sum_up = {1'b0, mid_q} + {1'b0, hi_q};
  assign sum_dn = {1'b0, lo_q} + {1'b0, mid_q};
  assign up_d   = sum_up[DataW:1];
  assign dn_d   = sum_dn[DataW:1];
  assign sq_d   = SqW'(mid_q) * SqW'(mid_q);

  assign target   = {{PadW{1'b0}}, val_q, {FRAC_BITS{1'b0}}};
  assign tol_wide = {{PadW{1'b0}}, tol_q, {FRAC_BITS{1'b0}}};
  assign sub_sq   = {1'b0, sq_q} - {1'b0, target};
  assign diff     = sub_sq[SqW] ? (target - sq_q) : sub_sq[SqW-1:0];

  assign flag_o.zero  = (value_i == '0);
  assign flag_o.one   = (value_i == One);
  assign flag_o.below = sub_sq[SqW];
  assign flag_o.hit   = (diff <= tol_wide);

  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    mid_d  = mid_q;
    root_d = root_q;
    if (cmd_i.load) begin
      lo_d   = '0;
      hi_d   = hi_init;
      mid_d  = hi_init >> 1;
      root_d = flag_o.zero ? '0 : One;
    end else if (cmd_i.step) begin
      if (flag_o.below) begin
        lo_d  = mid_q;
        mid_d = up_q;
      end else begin
        hi_d  = mid_q;
        mid_d = dn_q;
      end
    end else if (cmd_i.emit_mid) begin
      root_d = mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    root_q <= root_d;
    if (cmd_i.load) begin
      val_q <= value_i;
    end
    if (cmd_i.mul) begin
      sq_q <= sq_d;
      up_q <= up_d;
      dn_q <= dn_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: sv/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl
// Sequencer: accepts transactions, counts iterations and issues the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsr_ctrl #(
  parameter int MAX_ITERATIONS = bsr_pkg::MAX_ITER_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bsr_pkg::bsr_flag_t            flag_i,
  output bsr_pkg::bsr_cmd_t                  cmd_o,
  output logic                               valid_o,
  output logic [bsr_pkg::STATUS_W-1:0]       status_o,
  output logic [bsr_pkg::ITER_W-1:0]         iteration_o
);

  `include "bisection_square_root_top_assert.svh"

  localparam int IterW    = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int IterOutW = bsr_pkg::ITER_W;
  localparam logic [IterW-1:0] IterLast = IterW'(MAX_ITERATIONS - 1);

  bsr_pkg::state_e  state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             valid_q, valid_d;
  bsr_pkg::status_e status_q, status_d;
  logic [IterOutW-1:0] iter_out_q, iter_out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsr_pkg::S_IDLE;
      iter_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    iter_out_q <= iter_out_d;
  end

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    iter_out_d = iter_out_q;
    cmd_o      = '0;
    case (state_q)
      bsr_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          if (flag_i.zero || flag_i.one) begin
            valid_d    = 1'b1;
            status_d   = bsr_pkg::ST_EXACT;
            iter_out_d = '0;
          end else begin
            state_d = bsr_pkg::S_MUL;
          end
        end
      end
      bsr_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = bsr_pkg::S_CMP;
      end
      bsr_pkg::S_CMP: begin
        if (flag_i.hit) begin
          cmd_o.emit_mid = 1'b1;
          valid_d        = 1'b1;
          status_d       = bsr_pkg::ST_CONVERGED;
          iter_out_d     = IterOutW'(iter_q);
          state_d        = bsr_pkg::S_IDLE;
        end else if (iter_q == IterLast) begin
          cmd_o.emit_mid = 1'b1;
          valid_d        = 1'b1;
          status_d       = bsr_pkg::ST_NOT_CONVERGED;
          iter_out_d     = '0;
          state_d        = bsr_pkg::S_IDLE;
        end else begin
          // narrow the interval and go round again
          cmd_o.step = 1'b1;
          iter_d     = iter_q + IterW'(1);
          state_d    = bsr_pkg::S_MUL;
        end
      end
      default: begin
        state_d = bsr_pkg::S_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != bsr_pkg::S_IDLE);
  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign iteration_o = iter_out_q;

  `BSR_ASSERT_SAME(a_valid_when_idle, valid_q, state_q == bsr_pkg::S_IDLE, "result while busy")
  `BSR_ASSERT_NEXT(a_mul_then_cmp, state_q == bsr_pkg::S_MUL, state_q == bsr_pkg::S_CMP, "square not compared")
  `BSR_ASSERT_SAME(a_iter_bound, state_q != bsr_pkg::S_IDLE, iter_q <= IterLast, "iteration count past limit")
  `BSR_ASSERT_NEXT(a_special_exact, state_q == bsr_pkg::S_IDLE && start && (flag_i.zero || flag_i.one), valid_q && status_q == bsr_pkg::ST_EXACT, "endpoint case not exact")
  `BSR_ASSERT_SAME(a_noconv_iter, valid_q && status_q == bsr_pkg::ST_NOT_CONVERGED, iter_out_q == '0, "limit result with nonzero index")

endmodule

`default_nettype wire

FILE: sv/bisection_square_root_top.sv
// ----------------------------------------------------------------------------
// bisection_square_root_top
// Square root of an unsigned fixed-point number by interval bisection.
// ----------------------------------------------------------------------------
// Usage:
//   Drive value_i and raise start while busy is low; the transaction is taken
//   at that clock edge. busy stays high while the search runs.
//   Exactly one result follows each transaction: root_o, status_o and
//   iteration_o are valid for the single cycle in which valid_o is high.
//   The receiver cannot stall; it must take the result in that cycle.
//   A value of zero or of exactly 1.0 gives its result in the cycle after
//   acceptance. Otherwise each bisection step passes through a square state
//   and a compare state on the shared 32x32 squaring multiplier and compare,
//   and the search ends when the square lies within tolerance of the value or
//   when the iteration limit is reached.
//   busy falls as valid_o rises, so the next start may be taken in the cycle
//   the result is shown.
//   tolerance_i is written at any edge with tolerance_we_i high; write it only
//   while busy is low. Reset clears the sequencer and sets tolerance to 66.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bisection_square_root_top #(
  parameter int MAX_ITERATIONS = bsr_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS      = bsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tolerance_we_i,
  input  wire logic [bsr_pkg::DATA_W-1:0]    tolerance_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bsr_pkg::DATA_W-1:0]    value_i,
  output logic                               valid_o,
  output logic [bsr_pkg::DATA_W-1:0]         root_o,
  output logic [bsr_pkg::STATUS_W-1:0]       status_o,
  output logic [bsr_pkg::ITER_W-1:0]         iteration_o
);

  bsr_pkg::bsr_cmd_t  cmd;
  bsr_pkg::bsr_flag_t flag;

  bsr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tolerance_we_i (tolerance_we_i),
    .tolerance_i    (tolerance_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .flag_o         (flag),
    .root_o         (root_o)
  );

  bsr_ctrl #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .flag_i      (flag),
    .cmd_o       (cmd),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .iteration_o (iteration_o)
  );

endmodule

`default_nettype wire
